// ===== hw/rtl/irt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

  // Opcodes of an input item.
  localparam logic [1:0] OP_SQRT  = 2'd0;
  localparam logic [1:0] OP_CBRT  = 2'd1;
  localparam logic [1:0] OP_RSQRT = 2'd2;

  // Step counts of the three iterations.
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned CBRT_STEPS = 11;
  localparam int unsigned SQRT_STEPS = 32;

  // Register stages behind the input register, then the result register.
  localparam int unsigned NUM_STAGES = DIV_STEPS + SQRT_STEPS;

  // Result of a reciprocal square root of zero.
  localparam logic [31:0] RSQRT_ZERO = 32'h7FFF_FFFF;

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic        valid;
    logic [1:0]  opcode;
    logic [31:0] radicand;
    logic [31:0] drem;   // remainder of (2^64-1) / radicand
    logic [63:0] quo;    // quotient bits so far
    logic [31:0] cx;     // cube root remainder
    logic [10:0] cy;     // cube root so far
    logic [33:0] srem;   // square root remainder
    logic [31:0] sroot;  // square root so far
    logic [63:0] mrad;   // square root radicand, top pair consumed next
  } irt_stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/irt_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irt_stage #(
  parameter int unsigned Idx = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irt_pkg::irt_stage_t   stage_i,
  output irt_pkg::irt_stage_t   stage_o
);
  import irt_pkg::*;

  localparam bit          DoDiv   = (Idx <= DIV_STEPS);
  localparam bit          DoCbrt  = (Idx <= CBRT_STEPS);
  localparam bit          DoSqrt  = (Idx > DIV_STEPS);
  localparam bit          SqFirst = (Idx == DIV_STEPS + 1);
  localparam int unsigned CbShift = DoCbrt ? (30 - 3 * (Idx - 1)) : 0;

  irt_stage_t  nxt;
  logic [32:0] dshift;
  logic [32:0] ddiff;
  logic        dge;
  logic [10:0] y2;
  logic [11:0] y2p1;
  logic [22:0] prod;
  logic [24:0] cb;
  logic [31:0] cbw;
  logic        cge;
  logic [33:0] srem_s;
  logic [31:0] root_s;
  logic [63:0] mrad_s;
  logic [35:0] st;
  logic [35:0] strial;
  logic [35:0] sdiff;
  logic        sge;

  // One step of each iteration that this stage owns.
  always_comb begin
    nxt = stage_i;

    // Restoring division step; the dividend is all ones.
    dshift = {stage_i.drem, 1'b1};
    dge    = (dshift >= {1'b0, stage_i.radicand});
    ddiff  = dshift - {1'b0, stage_i.radicand};
    if (DoDiv) begin
      nxt.drem = dge ? ddiff[31:0] : dshift[31:0];
      nxt.quo  = {stage_i.quo[62:0], dge};
    end

    // Cube root step: try y = 2y+1 against 3y(y+1)+1 at this bit position.
    y2   = {stage_i.cy[9:0], 1'b0};
    y2p1 = {1'b0, y2} + 12'd1;
    prod = 23'(y2 * y2p1);
    cb   = {1'b0, prod, 1'b0} + {2'b0, prod} + 25'd1;
    cbw  = {7'b0, cb};
    cge  = ((stage_i.cx >> CbShift) >= cbw);
    if (DoCbrt && cge) begin
      nxt.cx = stage_i.cx - (cbw << CbShift);
      nxt.cy = y2p1[10:0];
    end else if (DoCbrt) begin
      nxt.cy = y2;
    end

    // Square root step, two radicand bits at a time.
    if (SqFirst) begin
      srem_s = '0;
      root_s = '0;
      mrad_s = (stage_i.opcode == OP_RSQRT) ? stage_i.quo : {32'b0, stage_i.radicand};
    end else begin
      srem_s = stage_i.srem;
      root_s = stage_i.sroot;
      mrad_s = stage_i.mrad;
    end
    st     = {srem_s, mrad_s[63:62]};
    strial = {2'b0, root_s, 2'b01};
    sge    = (st >= strial);
    sdiff  = st - strial;
    if (DoSqrt) begin
      nxt.srem  = sge ? sdiff[33:0] : st[33:0];
      nxt.sroot = {root_s[30:0], sge};
      nxt.mrad  = {mrad_s[61:0], 2'b00};
    end
  end

  // Stage register; reset clears the whole item, valid bit included.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_o <= '0;
    end else begin
      stage_o <= nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_root_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Transfer
// command   start_i, opcode_i,           start_i high while busy_o low
//           radicand_i, busy_o
// result    done_o, root_o               done_o high for one cycle
//
// A command enters every cycle; busy_o stays low. Each result passes through one input
// register, 64 division steps, 32 square root steps and the result register, one step
// per stage. Results leave in command order. Reset clears the pipeline registers and
// the result strobe. The receiver cannot stall.
module integer_root_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import irt_pkg::*;

  irt_stage_t  pipe [0:NUM_STAGES];
  irt_stage_t  stage0_d;
  logic        done_q;
  logic [31:0] root_q;
  logic [31:0] root_d;
  logic [32:0] rs_inc;
  irt_stage_t  last;

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // Input register.
  always_comb begin
    stage0_d          = '0;
    stage0_d.valid    = start_i;
    stage0_d.opcode   = opcode_i;
    stage0_d.radicand = radicand_i;
    stage0_d.cx       = radicand_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe[0] <= '0;
    end else begin
      pipe[0] <= stage0_d;
    end
  end

  // Step stages.
  for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_stage
    irt_stage #(
      .Idx(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .stage_i(pipe[g-1]),
      .stage_o(pipe[g])
    );
  end

  // Pick the result by opcode.
  always_comb begin
    last   = pipe[NUM_STAGES];
    rs_inc = {1'b0, last.sroot} + 33'd1;
    case (last.opcode)
      OP_SQRT:  root_d = last.sroot;
      OP_CBRT:  root_d = {21'b0, last.cy};
      OP_RSQRT: root_d = (last.radicand == 32'd0) ? RSQRT_ZERO : rs_inc[32:1];
      default:  root_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

  // Every accepted command yields exactly one result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##98 done_o)
    else $error("accepted command produced no result");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 98))
    else $error("result without a command");

  a_rsqrt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && last.opcode == OP_RSQRT && last.radicand == 32'd0)
      |=> (root_o == RSQRT_ZERO))
    else $error("reciprocal of zero has wrong result");

endmodule

`default_nettype wire

// ===== tb/tb_integer_root_unit_top.sv =====
`timescale 1ns / 1ps

module tb_integer_root_unit_top;
  import irt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned LATENCY = 98;
  localparam int unsigned CUBE_LIMIT = 1625;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  opcode_i;
  logic [31:0] radicand_i;
  logic        done_o;
  logic [31:0] root_o;

  // Roots still in flight, oldest first.
  logic [31:0] pending_roots[$];
  int unsigned error_count;
  int unsigned idle_pct;

  integer_root_unit_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .opcode_i   (opcode_i),
    .radicand_i (radicand_i),
    .done_o     (done_o),
    .root_o     (root_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_integer_root_unit_top: FAIL");
    $finish;
  end

  // Floor square root of a 32-bit value, one bit at a time.
  function automatic logic [31:0] floor_sqrt(input logic [31:0] d);
    logic [63:0] q;
    logic [63:0] c;
    q = '0;
    for (int k = 15; k >= 0; k--) begin
      c = q + (64'd1 << k);
      if ({32'd0, d} >= c * c) q = c;
    end
    return q[31:0];
  endfunction

  // Floor cube root, candidates capped at 1625, the root of the largest cube below 2^32.
  function automatic logic [31:0] floor_cbrt(input logic [31:0] d);
    logic [63:0] q;
    logic [63:0] c;
    q = '0;
    for (int k = 10; k >= 0; k--) begin
      c = q + (64'd1 << k);
      if (c <= CUBE_LIMIT && {32'd0, d} >= c * c * c) q = c;
    end
    return q[31:0];
  endfunction

  // Rounded 2^31 / sqrt(d) through the floor square root of (2^64-1)/d.
  function automatic logic [31:0] recip_sqrt(input logic [31:0] d);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] c;
    logic [127:0] sq;
    logic [63:0] r;
    if (d == '0) return RSQRT_ZERO;
    m = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, d};
    q = '0;
    for (int k = 31; k >= 0; k--) begin
      c = q + (64'd1 << k);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= {64'd0, m}) q = c;
    end
    r = (q + 64'd1) >> 1;
    return r[31:0];
  endfunction

  function automatic logic [31:0] predict_root(input logic [1:0] op, input logic [31:0] d);
    case (op)
      OP_SQRT:  return floor_sqrt(d);
      OP_CBRT:  return floor_cbrt(d);
      OP_RSQRT: return recip_sqrt(d);
      default:  return '0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Send one command and hold start until the transfer happens.
  // Start stays high afterwards until the next idle cycle or the caller drops it.
  task automatic send_command(input logic [1:0] op, input logic [31:0] d);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    opcode_i   <= op;
    radicand_i <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_roots.push_back(predict_root(op, d));
  endtask

  // Check each result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected root %h", root_o));
      end else begin
        logic [31:0] exp_root;
        exp_root = pending_roots.pop_front();
        if (root_o !== exp_root)
          report_mismatch($sformatf("root %h, expected %h", root_o, exp_root));
      end
    end
  end

  task automatic wait_drained();
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] edges[] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF,
                             32'hFFFE_0001, 32'hFFFE_0000, 32'd4291015625,
                             32'd4291015624, 32'h8000_0000};
    foreach (edges[i]) begin
      send_command(OP_SQRT, edges[i]);
      send_command(OP_CBRT, edges[i]);
    end
    send_command(OP_RSQRT, 32'd0);
    send_command(OP_RSQRT, 32'd1);
    send_command(OP_RSQRT, 32'hFFFF_FFFF);
    send_command(OP_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(input int unsigned count);
    logic [31:0] d;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(3, 0))
        0: d = $urandom_range(64, 0);
        1: d = $urandom() >> $urandom_range(31, 0);
        default: d = $urandom();
      endcase
      send_command($urandom_range(15, 0) == 0 ? OP_UNUSED : 2'($urandom_range(2, 0)), d);
    end
  endtask

  initial begin
    error_count = 0;
    idle_pct    = 17;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    opcode_i    = OP_SQRT;
    radicand_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    // Pause until every root has arrived.
    start_i <= 1'b0;
    wait_drained();
    idle_pct = 64;
    test_random(200);
    idle_pct = 0;
    test_random(300);
    start_i <= 1'b0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_integer_root_unit_top: PASS");
    end else begin
      $display("tb_integer_root_unit_top: FAIL");
    end
    $finish;
  end

endmodule
